@@ rtl/pace_pkg.sv @@
// Shared constants and saturating helpers for the autocorrelation energy core.
`timescale 1ns / 1ps
`default_nettype none
package pace_pkg;

  localparam int unsigned ENERGY_W = 63;
  localparam int unsigned K_W      = 20;
  localparam int unsigned MUL_W    = 33;
  localparam int unsigned WIDE_W   = 64;

  localparam logic [ENERGY_W-1:0] ENERGY_CAP = {ENERGY_W{1'b1}};
  localparam logic [WIDE_W-1:0]   SQRT_CAP   = 64'd3037000499;
  localparam logic [ENERGY_W-1:0] ODD_PENALTY = 63'd4;

  typedef logic [ENERGY_W-1:0] energy_t;

  // add two energies, clamp at the cap
  function automatic energy_t sat_add(input energy_t a, input energy_t b);
    logic [ENERGY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ENERGY_W] ? ENERGY_CAP : s[ENERGY_W-1:0];
  endfunction

  // multiply by four, clamp at the cap
  function automatic energy_t sat_x4(input energy_t v);
    return (|v[ENERGY_W-1:ENERGY_W-2]) ? ENERGY_CAP : {v[ENERGY_W-3:0], 2'b00};
  endfunction

endpackage
`default_nettype wire

@@ rtl/pace_store.sv @@
// Sequence store: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module pace_store #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9,
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [DATA_W-1:0] rdata_a_r,
  output logic      [DATA_W-1:0] rdata_b_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

endmodule
`default_nettype wire

@@ rtl/pace_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module pace_mul (
  input  wire logic                                  clk,
  input  wire logic signed [pace_pkg::MUL_W-1:0]     op_a,
  input  wire logic signed [pace_pkg::MUL_W-1:0]     op_b,
  output logic      signed [2*pace_pkg::MUL_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule
`default_nettype wire

@@ rtl/periodic_autocorrelation_energy_core.sv @@
// Top level: sequence loading, lag-sum sequencer and energy accumulation.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel  Ports                              Transfer when
//  -------  ---------------------------------  ----------------------------
//  input    in_valid/in_ready, entry, is_last  in_valid && in_ready
//  result   out_valid/out_ready, energy, flags out_valid && out_ready
//  config   cfg_we, cfg_wdata (target_k)       cfg_we high at the edge
//
//  Entries load at one per cycle while in_ready is high. The closing entry
//  starts an evaluation of the d stored entries: each lag issues d pairs to
//  the single multiplier and drains it, each nonzero lag a square and an
//  add; the zero-lag term and an absolute sum over the target one each.
//  Synchronous active-low reset clears the sequencer, counters and flags;
//  the sequence store needs no clearing, only written entries are read.
//  A result waiting on out_ready does not block loading the next sequence.
//
module periodic_autocorrelation_energy_core #(
  parameter int unsigned MAX_LEN    = 512,
  parameter int unsigned ENTRY_BITS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [ENTRY_BITS-1:0]     in_entry_value,
  input  wire logic                             in_is_last,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [pace_pkg::ENERGY_W-1:0]         out_energy,
  output logic                                  out_is_feasible,
  output logic                                  out_too_long,
  input  wire logic                             cfg_we,
  input  wire logic [pace_pkg::K_W-1:0]         cfg_wdata
);

  localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned LAG_W  = 2 * ENTRY_BITS + CNT_W;
  localparam int unsigned ABS_W  = ENTRY_BITS + CNT_W;
  localparam int unsigned MW     = pace_pkg::MUL_W;
  localparam int unsigned WW     = pace_pkg::WIDE_W;
  localparam int unsigned EW     = pace_pkg::ENERGY_W;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_LAG   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SQ    = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_ABS   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [1:0] T_LAG = 2'd0;
  localparam logic [1:0] T_P0  = 2'd1;
  localparam logic [1:0] T_ABS = 2'd2;

  // ---------------------------------------------------------------- registers
  logic [2:0]              state_r, state_nxt;
  logic [1:0]              term_r, term_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [ABS_W-1:0]        abs_r, abs_nxt;
  logic [pace_pkg::K_W-1:0] target_r;
  logic [ADDR_W-1:0]       u_r, u_nxt;
  logic [ADDR_W-1:0]       i_r, i_nxt;
  logic [ADDR_W-1:0]       j_r, j_nxt;
  logic signed [LAG_W-1:0] acc_r, acc_nxt;
  logic signed [LAG_W-1:0] p0_r, p0_nxt;
  pace_pkg::energy_t       energy_r, energy_nxt;
  logic                    sq_big_r, sq_big_nxt;
  logic                    s1_vld_r, s1_vld_nxt, s1_first_r, s1_first_nxt;
  logic                    s2_vld_r, s2_first_r;
  logic                    out_valid_r, out_valid_nxt;
  pace_pkg::energy_t       out_energy_r, out_energy_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  // --------------------------------------------------------------- datapath
  logic                    in_xfer;
  logic                    store_we;
  logic [ENTRY_BITS-1:0]   rd_a, rd_b;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [2*MW-1:0]  prod;
  logic [CNT_W-1:0]        d_m1;
  logic [ENTRY_BITS-1:0]   entry_mag;
  logic [LAG_W-1:0]        acc_mag;
  logic signed [WW-1:0]    p0_diff;
  logic [WW-1:0]           sq_op;
  pace_pkg::energy_t       sq_val, term_val;
  logic                    room;
  logic                    abs_gt_k;

  assign in_ready = (state_r == S_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign room     = (count_r < CNT_W'(MAX_LEN));
  assign store_we = in_xfer && room;
  assign d_m1     = count_r - CNT_W'(1);

  assign entry_mag = in_entry_value[ENTRY_BITS-1] ? (~in_entry_value + ENTRY_BITS'(1))
                                                  : in_entry_value;
  assign acc_mag   = acc_r[LAG_W-1] ? LAG_W'(~acc_r + LAG_W'(1)) : LAG_W'(acc_r);
  assign p0_diff   = {{(WW-LAG_W){p0_r[LAG_W-1]}}, p0_r} - $signed(WW'(target_r));
  assign abs_gt_k  = (WW'(abs_r) > WW'(target_r));

  // operand of the square, one term at a time
  always_comb begin
    case (term_r)
      T_LAG:   sq_op = WW'(acc_mag);
      T_P0:    sq_op = p0_diff[WW-1] ? (~p0_diff + WW'(1)) : p0_diff;
      T_ABS:   sq_op = WW'(abs_r) - WW'(target_r);
      default: sq_op = '0;
    endcase
  end

  // pipeline owns the multiplier while pairs are in flight
  always_comb begin
    if (s1_vld_r) begin
      mul_a = {{(MW-ENTRY_BITS){rd_a[ENTRY_BITS-1]}}, rd_a};
      mul_b = {{(MW-ENTRY_BITS){rd_b[ENTRY_BITS-1]}}, rd_b};
    end else begin
      mul_a = {1'b0, sq_op[MW-2:0]};
      mul_b = {1'b0, sq_op[MW-2:0]};
    end
  end

  assign sq_val   = sq_big_r ? pace_pkg::ENERGY_CAP : pace_pkg::energy_t'(prod[EW-1:0]);
  assign term_val = (term_r == T_LAG) ? sq_val : pace_pkg::sat_x4(sq_val);

  pace_store #(
    .DEPTH  (MAX_LEN),
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_BITS)
  ) u_store (
    .clk       (clk),
    .we        (store_we),
    .waddr     (count_r[ADDR_W-1:0]),
    .wdata     (in_entry_value),
    .raddr_a   (i_r),
    .raddr_b   (j_r),
    .rdata_a_r (rd_a),
    .rdata_b_r (rd_b)
  );

  pace_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt      = state_r;
    term_nxt       = term_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    abs_nxt        = abs_r;
    u_nxt          = u_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    acc_nxt        = acc_r;
    p0_nxt         = p0_r;
    energy_nxt     = energy_r;
    sq_big_nxt     = sq_big_r;
    s1_vld_nxt     = 1'b0;
    s1_first_nxt   = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_energy_nxt = out_energy_r;
    out_ovf_nxt    = out_ovf_r;

    // stage two: fold the product into the running lag sum
    if (s2_vld_r) begin
      acc_nxt = (s2_first_r ? LAG_W'(0) : acc_r) + prod[LAG_W-1:0];
    end

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (room) begin
            count_nxt = count_r + CNT_W'(1);
            abs_nxt   = abs_r + ABS_W'(entry_mag);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last) begin
            energy_nxt = '0;
            term_nxt   = T_LAG;
            u_nxt      = '0;
            i_nxt      = '0;
            j_nxt      = '0;
            state_nxt  = S_LAG;
          end
        end
      end
      S_LAG: begin
        // issue one pair per cycle
        s1_vld_nxt   = 1'b1;
        s1_first_nxt = (i_r == '0);
        if (CNT_W'(i_r) == d_m1) begin
          state_nxt = S_DRAIN;
        end else begin
          i_nxt = i_r + ADDR_W'(1);
          j_nxt = (CNT_W'(j_r) == d_m1) ? '0 : j_r + ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r) begin
          if (u_r == '0) begin
            p0_nxt = acc_r;
            if (CNT_W'(u_r) == d_m1) begin
              term_nxt  = T_P0;
              state_nxt = S_SQ;
            end else begin
              u_nxt     = u_r + ADDR_W'(1);
              i_nxt     = '0;
              j_nxt     = u_r + ADDR_W'(1);
              state_nxt = S_LAG;
            end
          end else begin
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        sq_big_nxt = (sq_op > pace_pkg::SQRT_CAP);
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        energy_nxt = pace_pkg::sat_add(energy_r, term_val);
        case (term_r)
          T_LAG: begin
            if (CNT_W'(u_r) == d_m1) begin
              term_nxt  = T_P0;
              state_nxt = S_SQ;
            end else begin
              u_nxt     = u_r + ADDR_W'(1);
              i_nxt     = '0;
              j_nxt     = u_r + ADDR_W'(1);
              state_nxt = S_LAG;
            end
          end
          T_P0:    state_nxt = S_ABS;
          default: state_nxt = S_OUT;
        endcase
      end
      S_ABS: begin
        if (abs_gt_k) begin
          term_nxt  = T_ABS;
          state_nxt = S_SQ;
        end else begin
          // odd gap between target and absolute sum
          if (abs_r[0] ^ target_r[0]) begin
            energy_nxt = pace_pkg::sat_add(energy_r, pace_pkg::ODD_PENALTY);
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_energy_nxt = energy_r;
          out_ovf_nxt    = ovf_r;
          count_nxt      = '0;
          ovf_nxt        = 1'b0;
          abs_nxt        = '0;
          state_nxt      = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      term_r      <= T_LAG;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      abs_r       <= '0;
      target_r    <= '0;
      u_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      acc_r       <= '0;
      p0_r        <= '0;
      energy_r    <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_r      <= term_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      abs_r       <= abs_nxt;
      u_r         <= u_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      acc_r       <= acc_nxt;
      p0_r        <= p0_nxt;
      energy_r    <= energy_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    sq_big_r     <= sq_big_nxt;
    s1_first_r   <= s1_first_nxt;
    s2_first_r   <= s1_first_r;
    out_energy_r <= out_energy_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_energy      = out_energy_r;
  assign out_is_feasible = (out_energy_r == '0);
  assign out_too_long    = out_ovf_r;

  // ------------------------------------------------------------- assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_LEN))
    else $error("entry count beyond store depth");

  a_pipe_in_lag: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (state_r == S_LAG || state_r == S_DRAIN))
    else $error("pair product in flight outside lag phase");

  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |-> (!s1_vld_r && !s2_vld_r))
    else $error("square issued while multiplier busy with pairs");

  a_add_after_sq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |=> (state_r == S_ADD))
    else $error("square not followed by accumulation");

endmodule
`default_nettype wire

@@ test/autocorr_energy_checker.sv @@
// Checker: predicts the sidelobe energy of each closed sequence and compares the core's results.
`timescale 1ns / 1ps
module autocorr_energy_checker #(
  parameter int unsigned MAX_LEN    = 512,
  parameter int unsigned ENTRY_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [ENTRY_BITS-1:0]  in_entry_value,
  input  logic                          in_is_last,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [pace_pkg::ENERGY_W-1:0] out_energy,
  input  logic                          out_is_feasible,
  input  logic                          out_too_long,
  input  logic                          cfg_we,
  input  logic [pace_pkg::K_W-1:0]      cfg_wdata,
  output int unsigned                   mismatches,
  output int unsigned                   awaiting
);

  localparam logic [63:0] ENERGY_LIMIT    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ROOT_LIMIT      = 64'd3037000499;
  localparam logic [63:0] ODD_GAP_PENALTY = 64'd4;

  typedef struct packed {
    logic [pace_pkg::ENERGY_W-1:0] energy;
    logic                          feasible;
    logic                          too_long;
  } energy_result_t;

  logic signed [ENTRY_BITS-1:0] loaded_entries [MAX_LEN];
  int unsigned                  loaded_count;
  logic                         dropped_any;
  logic [pace_pkg::K_W-1:0]     target_k;
  energy_result_t               pending_energies [$];

  function automatic logic [63:0] capped_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, ENERGY_LIMIT}) ? ENERGY_LIMIT : s[63:0];
  endfunction

  function automatic logic [63:0] capped_square(input logic [63:0] m);
    return (m > ROOT_LIMIT) ? ENERGY_LIMIT : m * m;
  endfunction

  function automatic logic [63:0] capped_x4(input logic [63:0] v);
    return (v > (ENERGY_LIMIT >> 2)) ? ENERGY_LIMIT : (v << 2);
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Sum of squared cyclic lag sums at nonzero lags, plus the peak and abs-sum penalties.
  function automatic logic [63:0] sidelobe_energy();
    longint      lag_total;
    longint      zero_lag;
    longint      abs_total;
    longint      k;
    int unsigned j;
    logic [63:0] total;
    total     = '0;
    zero_lag  = 0;
    abs_total = 0;
    k         = longint'(target_k);
    for (int unsigned u = 0; u < loaded_count; u++) begin
      lag_total = 0;
      for (int unsigned i = 0; i < loaded_count; i++) begin
        j = i + u;
        if (j >= loaded_count) j = j - loaded_count;
        lag_total += longint'(loaded_entries[i]) * longint'(loaded_entries[j]);
      end
      if (u == 0) zero_lag = lag_total;
      else total = capped_add(total, capped_square(magnitude(lag_total)));
    end
    total = capped_add(total, capped_x4(capped_square(magnitude(zero_lag - k))));
    for (int unsigned i = 0; i < loaded_count; i++)
      abs_total += longint'(magnitude(longint'(loaded_entries[i])));
    if (abs_total > k)
      total = capped_add(total, capped_x4(capped_square(64'(abs_total - k))));
    else if (((k - abs_total) & 64'd1) != 0)
      total = capped_add(total, ODD_GAP_PENALTY);
    return total;
  endfunction

  always @(posedge clk) begin : watch
    energy_result_t want;
    logic [63:0]    total;
    if (!rst_n) begin
      loaded_count = 0;
      dropped_any  = 1'b0;
      target_k     = '0;
      mismatches   = 0;
      pending_energies.delete();
    end else begin
      if (cfg_we) target_k = cfg_wdata;
      if (in_valid && in_ready) begin
        // store while there is room, otherwise drop and remember it
        if (loaded_count < MAX_LEN) begin
          loaded_entries[loaded_count] = in_entry_value;
          loaded_count++;
        end else begin
          dropped_any = 1'b1;
        end
        if (in_is_last) begin
          total         = sidelobe_energy();
          want.energy   = total[pace_pkg::ENERGY_W-1:0];
          want.feasible = (total == '0);
          want.too_long = dropped_any;
          pending_energies.push_back(want);
          loaded_count = 0;
          dropped_any  = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (pending_energies.size() == 0) begin
          $display("%0t: unexpected result, energy %0d", $time, out_energy);
          mismatches++;
        end else begin
          want = pending_energies.pop_front();
          if (out_energy !== want.energy) begin
            $display("%0t: energy expected %0d, got %0d", $time, want.energy, out_energy);
            mismatches++;
          end
          if (out_is_feasible !== want.feasible) begin
            $display("%0t: is_feasible expected %0b, got %0b", $time, want.feasible,
                     out_is_feasible);
            mismatches++;
          end
          if (out_too_long !== want.too_long) begin
            $display("%0t: too_long expected %0b, got %0b", $time, want.too_long,
                     out_too_long);
            mismatches++;
          end
        end
      end
    end
    awaiting = pending_energies.size();
  end

endmodule

@@ test/tb.sv @@
// Testbench top: drives sequences and target writes into the energy core and reports the verdict.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned SEQ_DEPTH   = 512;
  localparam int unsigned ENTRY_W     = 8;
  localparam int unsigned ITEM_TARGET = 1170;
  // The longest quiet stretch is one evaluation of a full store, with no
  // transfer. The limit allows about four times that.
  localparam int unsigned STALL_LIMIT = 1_100_000;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef enum int unsigned {SEQ_BINARY, SEQ_SMALL, SEQ_FULL, SEQ_CORNER, SEQ_FLOOR} seq_kind_t;

  localparam entry_t                   ENTRY_MIN  = {1'b1, {(ENTRY_W-1){1'b0}}};
  localparam entry_t                   ENTRY_MAX  = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam logic [pace_pkg::K_W-1:0] TARGET_MAX = '1;

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          in_valid        = 1'b0;
  logic                          in_ready;
  entry_t                        in_entry_value  = '0;
  logic                          in_is_last      = 1'b0;
  logic                          out_valid;
  logic                          out_ready       = 1'b0;
  logic [pace_pkg::ENERGY_W-1:0] out_energy;
  logic                          out_is_feasible;
  logic                          out_too_long;
  logic                          cfg_we          = 1'b0;
  logic [pace_pkg::K_W-1:0]      cfg_wdata       = '0;

  wire [31:0] check_errors;
  wire [31:0] check_pending;

  int unsigned entries_sent     = 0;
  int unsigned sequences_sent   = 0;
  int unsigned settings_written = 0;
  int unsigned idle_cycles      = 0;

  // One long stretch of the random part runs with neither side idling.
  wire calm_window = (entries_sent >= 700) && (entries_sent < 860);

  always #10 clk = ~clk;

  periodic_autocorrelation_energy_core #(
    .MAX_LEN    (SEQ_DEPTH),
    .ENTRY_BITS (ENTRY_W)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_entry_value  (in_entry_value),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_energy      (out_energy),
    .out_is_feasible (out_is_feasible),
    .out_too_long    (out_too_long),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  autocorr_energy_checker #(
    .MAX_LEN    (SEQ_DEPTH),
    .ENTRY_BITS (ENTRY_W)
  ) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_entry_value  (in_entry_value),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_energy      (out_energy),
    .out_is_feasible (out_is_feasible),
    .out_too_long    (out_too_long),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (check_errors),
    .awaiting        (check_pending)
  );

  // Result side: drop out_ready at random with a 12 percent chance, never in the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm_window || ($urandom_range(0, 99) >= 12);
  end

  // Hang detector: count cycles in which neither channel makes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic entry_t draw_entry(input seq_kind_t kind);
    int unsigned pick;
    case (kind)
      SEQ_BINARY: return $urandom_range(0, 1) ? entry_t'(1) : entry_t'(-1);
      SEQ_SMALL:  return entry_t'(int'($urandom_range(0, 6)) - 3);
      SEQ_FULL:   return entry_t'($urandom_range(0, 255));
      SEQ_CORNER: begin
        pick = $urandom_range(0, 4);
        case (pick)
          0:       return ENTRY_MIN;
          1:       return ENTRY_MAX;
          2:       return entry_t'(0);
          3:       return entry_t'(1);
          default: return entry_t'(-1);
        endcase
      end
      default:    return ENTRY_MIN;
    endcase
  endfunction

  // Favour +/-1 sequences, the shape a sequence search feeds the core.
  function automatic seq_kind_t pick_kind();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return SEQ_BINARY;
    if (roll < 6) return SEQ_SMALL;
    if (roll < 8) return SEQ_FULL;
    return SEQ_CORNER;
  endfunction

  // Targets range from zero to the largest; a third of the draws are small, near typical lengths.
  function automatic logic [pace_pkg::K_W-1:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return TARGET_MAX;
      2, 3:    return pace_pkg::K_W'($urandom_range(1, 24));
      4:       return pace_pkg::K_W'($urandom_range(0, 20'hFFFFF));
      default: return pace_pkg::K_W'($urandom_range(1, 4096));
    endcase
  endfunction

  // Offer one entry; idle first at random, then hold it until the transfer.
  task automatic push_entry(input entry_t value, input logic last);
    int unsigned gap;
    gap = 0;
    if (!calm_window) while ($urandom_range(0, 99) < 12) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_entry_value <= value;
    in_is_last     <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    entries_sent++;
    if (last) sequences_sent++;
  endtask

  task automatic push_sequence(input int unsigned length, input seq_kind_t kind);
    for (int unsigned i = 0; i < length; i++) push_entry(draw_entry(kind), i == length - 1);
  endtask

  // Drain every outstanding result, let the core settle, then write the target.
  task automatic set_target(input logic [pace_pkg::K_W-1:0] k);
    in_valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero target: a lone zero is feasible; lone extremes overshoot the sum.
    set_target('0);
    push_entry(entry_t'(0), 1'b1);
    push_entry(ENTRY_MAX, 1'b1);
    push_entry(ENTRY_MIN, 1'b1);

    // Target 4: a perfect length-4 sequence, a short one under target, one over.
    set_target(pace_pkg::K_W'(4));
    push_entry(entry_t'(1), 1'b0);
    push_entry(entry_t'(1), 1'b0);
    push_entry(entry_t'(1), 1'b0);
    push_entry(entry_t'(-1), 1'b1);
    push_entry(entry_t'(1), 1'b0);
    push_entry(entry_t'(1), 1'b1);
    push_entry(entry_t'(2), 1'b0);
    push_entry(entry_t'(-3), 1'b1);

    // Largest target: the absolute sum falls short by an odd amount.
    set_target(TARGET_MAX);
    push_entry(ENTRY_MIN, 1'b0);
    push_entry(ENTRY_MAX, 1'b0);
    push_entry(entry_t'(-1), 1'b0);
    push_entry(entry_t'(0), 1'b0);
    push_entry(entry_t'(4), 1'b1);

    // Target 1: single +1 and -1 are both feasible.
    set_target(pace_pkg::K_W'(1));
    push_entry(entry_t'(1), 1'b1);
    push_entry(entry_t'(-1), 1'b1);

    // Over-length sequence of all minimum entries: the store fills, the tail is
    // dropped, the closing entry among it, and the lag sums reach their largest.
    set_target(pace_pkg::K_W'(4096));
    push_sequence(SEQ_DEPTH + 3, SEQ_FLOOR);

    // Random phases: a fresh target, then a handful of mostly short sequences.
    while (entries_sent < ITEM_TARGET) begin
      set_target(pick_target());
      repeat ($urandom_range(3, 10)) begin
        if ($urandom_range(0, 9) == 0) push_sequence($urandom_range(17, 40), pick_kind());
        else push_sequence($urandom_range(1, 16), pick_kind());
      end
    end

    // Drain, then give the core time to show any stray result.
    in_valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    $display("Sent %0d entries in %0d sequences under %0d target settings,", entries_sent,
             sequences_sent, settings_written);
    $display("including one sequence that overran the %0d-entry store.", SEQ_DEPTH);
    if (check_errors == 0 && check_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pace_pkg.sv
rtl/pace_store.sv
rtl/pace_mul.sv
rtl/periodic_autocorrelation_energy_core.sv
test/autocorr_energy_checker.sv
test/tb.sv
